// File: hw/rtl/ac_input_presence_qualifier_unit_macros.svh
// Assertion macros for the AC input presence qualifier.
// Included by the checker; needs nothing else.
`ifndef AC_INPUT_PRESENCE_QUALIFIER_UNIT_MACROS_SVH
`define AC_INPUT_PRESENCE_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AIPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("aipq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AIPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("aipq assertion failed");

`endif

// File: hw/rtl/aipq_pkg.sv
// Package of the AC input presence qualifier: types and fixed constants.
// Used by aipq_edge_count, aipq_window and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aipq_pkg;

  localparam int NumPins = 4;
  localparam int CfgW    = 8;
  localparam int TimerW  = 8;

  // Pin positions inside pin_levels and the qualified flags.
  localparam int PinVdet  = 0;
  localparam int PinSail  = 1;
  localparam int PinPower = 2;
  localparam int PinTco   = 3;

  localparam logic [TimerW-1:0] TimerMax = '1;

  localparam logic [CfgW-1:0] AcWindowRst    = 8'd60;
  localparam logic [CfgW-1:0] InWindowRst    = 8'd120;
  localparam logic [CfgW-1:0] AcThresholdRst = 8'd4;
  localparam logic [CfgW-1:0] InThresholdRst = 8'd5;

  typedef enum logic [1:0] {
    CfgAcWindow    = 2'd0,
    CfgInWindow    = 2'd1,
    CfgAcThreshold = 2'd2,
    CfgInThreshold = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] ac_window_ms;
    logic [CfgW-1:0] input_window_ms;
    logic [CfgW-1:0] ac_edge_threshold;
    logic [CfgW-1:0] input_edge_threshold;
  } cfg_t;

  // Counter clears requested by the window logic.
  typedef struct packed {
    logic ac;
    logic inputs;
  } win_clr_t;

endpackage

`default_nettype wire

// File: hw/rtl/aipq_if.sv
// Valid/ready channel interfaces of the AC input presence qualifier.
// Standalone; carries the pin sample in and the qualified flags out.
`timescale 1ns / 1ps
`default_nettype none

interface aipq_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] pin_levels;
  logic       ms_tick;

  modport source (output valid, output pin_levels, output ms_tick, input ready);
  modport sink   (input valid, input pin_levels, input ms_tick, output ready);
endinterface

interface aipq_out_if;
  logic valid;
  logic ready;
  logic ac_present;
  logic sail_switch_on;
  logic power_button_on;
  logic tco_on;

  modport source (output valid, output ac_present, output sail_switch_on,
                  output power_button_on, output tco_on, input ready);
  modport sink   (input valid, input ac_present, input sail_switch_on,
                  input power_button_on, input tco_on, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/aipq_edge_count.sv
// Level memory and saturating edge counters of the four pins.
// Depends on aipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aipq_edge_count #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire logic                                             step_i,
  input  wire logic [aipq_pkg::NumPins-1:0]                     levels_i,
  input  wire aipq_pkg::win_clr_t                               clr_i,
  output logic      [aipq_pkg::NumPins-1:0][COUNT_BITS-1:0]     cnt_inc_o
);

  logic [aipq_pkg::NumPins-1:0]                 prev_q;
  logic [aipq_pkg::NumPins-1:0][COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [aipq_pkg::NumPins-1:0]                 changed;

  always_comb begin
    changed = levels_i ^ prev_q;
    for (int i = 0; i < aipq_pkg::NumPins; i++) begin
      if (changed[i] && (cnt_q[i] != {COUNT_BITS{1'b1}})) begin
        cnt_inc_o[i] = cnt_q[i] + COUNT_BITS'(1);
      end else begin
        cnt_inc_o[i] = cnt_q[i];
      end
      if (i == aipq_pkg::PinVdet) begin
        cnt_d[i] = clr_i.ac ? '0 : cnt_inc_o[i];
      end else begin
        cnt_d[i] = clr_i.inputs ? '0 : cnt_inc_o[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      prev_q <= levels_i;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/aipq_window.sv
// Window timers and threshold evaluation producing the qualified flags.
// Depends on aipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aipq_window #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         step_i,
  input  wire logic                                         tick_i,
  input  wire aipq_pkg::cfg_t                               cfg_i,
  input  wire logic [aipq_pkg::NumPins-1:0][COUNT_BITS-1:0] cnt_i,
  output aipq_pkg::win_clr_t                                clr_o,
  output logic      [aipq_pkg::NumPins-1:0]                 flags_d_o
);

  localparam int CmpW = (COUNT_BITS > aipq_pkg::CfgW) ? COUNT_BITS : aipq_pkg::CfgW;

  logic [aipq_pkg::TimerW-1:0]  ac_tmr_q, ac_tmr_d, ac_adv;
  logic [aipq_pkg::TimerW-1:0]  in_tmr_q, in_tmr_d, in_adv;
  logic [aipq_pkg::NumPins-1:0] flags_q;
  logic                         ac_end, in_end, ac_new;

  always_comb begin
    ac_adv = (ac_tmr_q != aipq_pkg::TimerMax) ? ac_tmr_q + 8'd1 : ac_tmr_q;
    in_adv = (in_tmr_q != aipq_pkg::TimerMax) ? in_tmr_q + 8'd1 : in_tmr_q;
    ac_end = tick_i && (ac_adv >= cfg_i.ac_window_ms);
    in_end = tick_i && (in_adv >= cfg_i.input_window_ms);

    ac_tmr_d = ac_end ? '0 : (tick_i ? ac_adv : ac_tmr_q);
    in_tmr_d = in_end ? '0 : (tick_i ? in_adv : in_tmr_q);

    clr_o.ac     = ac_end;
    clr_o.inputs = in_end;

    // The switch inputs see the AC flag as just updated when both windows end.
    flags_d_o = flags_q;
    if (ac_end) begin
      flags_d_o[aipq_pkg::PinVdet] =
        CmpW'(cnt_i[aipq_pkg::PinVdet]) > CmpW'(cfg_i.ac_edge_threshold);
    end
    ac_new = flags_d_o[aipq_pkg::PinVdet];
    if (in_end) begin
      for (int i = 1; i < aipq_pkg::NumPins; i++) begin
        flags_d_o[i] = ac_new && (CmpW'(cnt_i[i]) > CmpW'(cfg_i.input_edge_threshold));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_tmr_q <= '0;
      in_tmr_q <= '0;
      flags_q  <= '0;
    end else if (step_i) begin
      ac_tmr_q <= ac_tmr_d;
      in_tmr_q <= in_tmr_d;
      flags_q  <= flags_d_o;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ac_input_presence_qualifier_unit.sv
// AC input presence qualifier, top level.
// Depends on aipq_pkg, aipq_if, aipq_edge_count and aipq_window.
//
// Usage: every transfer on in_if carries one sample of the four pin levels
// (voltage detect, sail switch, power button, thermal cutoff) and a flag
// that marks a one-millisecond tick. For every input transfer exactly one
// transfer on out_if follows, carrying the four qualified flags as they
// stand after that sample.
// The input register takes a sample at its transfer edge, and the result
// register takes the evaluated flags when the evaluation step fires; out_if
// is driven straight from the result register. Throughput is one item per
// cycle while out_if.ready stays high; the counters, timers and flags update
// in the same step that loads the result register.
// When the receiver holds out_if.ready low, the result register keeps its
// data and the input register fills; in_if.ready drops only once both hold
// an item, and the block resumes at full rate when ready returns.
// Reset clears counters, timers, flags and pending items, and loads the
// configuration registers with their defaults (60 ms, 120 ms, 4, 5).
// Configuration writes go through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// are meant to happen while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ac_input_presence_qualifier_unit #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  aipq_in_if.sink                        in_if,
  aipq_out_if.source                     out_if,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [aipq_pkg::CfgW-1:0] cfg_wdata_i
);

  aipq_pkg::cfg_t                               cfg_q;
  logic                                         in_vld_q;
  logic [aipq_pkg::NumPins-1:0]                 in_lvl_q;
  logic                                         in_tick_q;
  logic                                         out_vld_q;
  logic [aipq_pkg::NumPins-1:0]                 out_flags_q;
  logic                                         step;
  logic [aipq_pkg::NumPins-1:0][COUNT_BITS-1:0] cnt_inc;
  logic [aipq_pkg::NumPins-1:0]                 flags_d;
  aipq_pkg::win_clr_t                           clr;

  // The evaluation step fires when the input register holds a sample and the result register is free or drains now.
  assign step         = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ac_window_ms         <= aipq_pkg::AcWindowRst;
      cfg_q.input_window_ms      <= aipq_pkg::InWindowRst;
      cfg_q.ac_edge_threshold    <= aipq_pkg::AcThresholdRst;
      cfg_q.input_edge_threshold <= aipq_pkg::InThresholdRst;
    end else if (cfg_we_i) begin
      case (aipq_pkg::cfg_idx_e'(cfg_idx_i))
        aipq_pkg::CfgAcWindow:    cfg_q.ac_window_ms         <= cfg_wdata_i;
        aipq_pkg::CfgInWindow:    cfg_q.input_window_ms      <= cfg_wdata_i;
        aipq_pkg::CfgAcThreshold: cfg_q.ac_edge_threshold    <= cfg_wdata_i;
        aipq_pkg::CfgInThreshold: cfg_q.input_edge_threshold <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_lvl_q  <= in_if.pin_levels;
      in_tick_q <= in_if.ms_tick;
    end
    if (step) begin
      out_flags_q <= flags_d;
    end
  end

  aipq_edge_count #(
    .COUNT_BITS(COUNT_BITS)
  ) u_edge_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .levels_i (in_lvl_q),
    .clr_i    (clr),
    .cnt_inc_o(cnt_inc)
  );

  aipq_window #(
    .COUNT_BITS(COUNT_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .tick_i   (in_tick_q),
    .cfg_i    (cfg_q),
    .cnt_i    (cnt_inc),
    .clr_o    (clr),
    .flags_d_o(flags_d)
  );

  assign out_if.valid           = out_vld_q;
  assign out_if.ac_present      = out_flags_q[aipq_pkg::PinVdet];
  assign out_if.sail_switch_on  = out_flags_q[aipq_pkg::PinSail];
  assign out_if.power_button_on = out_flags_q[aipq_pkg::PinPower];
  assign out_if.tco_on          = out_flags_q[aipq_pkg::PinTco];

endmodule

`default_nettype wire

// File: hw/rtl/aipq_checker.sv
// Port-level checker of the AC input presence qualifier, bound to the top.
// Depends on ac_input_presence_qualifier_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ac_input_presence_qualifier_unit_macros.svh"

module aipq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [3:0] out_flags_i
);

  // A held result stays offered and unchanged.
  `AIPQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `AIPQ_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_flags_i))
  // Every accepted sample shows a result once it has passed the input and result registers.
  `AIPQ_ASSERT_IMP(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i, ##2 out_valid_i)
  // With the output side empty, the input side never pushes back.
  `AIPQ_ASSERT_IMP(a_no_backpressure, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind ac_input_presence_qualifier_unit aipq_checker u_aipq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_flags_i({out_if.tco_on, out_if.power_button_on, out_if.sail_switch_on,
                out_if.ac_present})
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench of the AC input presence qualifier unit.
// Needs aipq_pkg, the aipq_in_if/aipq_out_if interfaces and the RTL of the unit.
`timescale 1ns / 1ps

module tb;

  localparam int CountBits   = 8;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;
  localparam int NumPins     = aipq_pkg::NumPins;
  localparam int CfgW        = aipq_pkg::CfgW;

  typedef logic [NumPins-1:0] flags_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  aipq_pkg::cfg_idx_e cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  aipq_in_if  sample_ch ();
  aipq_out_if flags_ch ();

  ac_input_presence_qualifier_unit #(
    .COUNT_BITS(CountBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (sample_ch.sink),
    .out_if     (flags_ch.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the qualifier: configuration, counters, timers and flags.
  aipq_pkg::cfg_t              shadow_cfg;
  logic [NumPins-1:0]          seen_levels;
  logic [CountBits-1:0]        edge_cnt [NumPins];
  logic [aipq_pkg::TimerW-1:0] ac_elapsed;
  logic [aipq_pkg::TimerW-1:0] in_elapsed;
  flags_t                      qual_flags;
  flags_t                      flags_due [$];

  int                   fail_count;
  int                   idle_cycles;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  logic [NumPins-1:0]   last_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_shadow();
    shadow_cfg = '{ac_window_ms: aipq_pkg::AcWindowRst,
                   input_window_ms: aipq_pkg::InWindowRst,
                   ac_edge_threshold: aipq_pkg::AcThresholdRst,
                   input_edge_threshold: aipq_pkg::InThresholdRst};
    seen_levels = '0;
    foreach (edge_cnt[p]) edge_cnt[p] = '0;
    ac_elapsed = '0;
    in_elapsed = '0;
    qual_flags = '0;
  endtask

  // Counts edges of one sample, then runs the window timers on a tick. The AC
  // window is evaluated before the switch inputs, which use the new AC flag.
  task automatic qualify_sample(input logic [NumPins-1:0] levels, input logic tick);
    logic [NumPins-1:0] changed;
    changed = levels ^ seen_levels;
    for (int p = 0; p < NumPins; p++) begin
      if (changed[p] && edge_cnt[p] != '1) edge_cnt[p] = edge_cnt[p] + 1'b1;
    end
    seen_levels = levels;
    if (tick) begin
      if (ac_elapsed != aipq_pkg::TimerMax) ac_elapsed = ac_elapsed + 1'b1;
      if (in_elapsed != aipq_pkg::TimerMax) in_elapsed = in_elapsed + 1'b1;
      if (ac_elapsed >= shadow_cfg.ac_window_ms) begin
        ac_elapsed = '0;
        qual_flags[aipq_pkg::PinVdet] =
          edge_cnt[aipq_pkg::PinVdet] > shadow_cfg.ac_edge_threshold;
        edge_cnt[aipq_pkg::PinVdet] = '0;
      end
      if (in_elapsed >= shadow_cfg.input_window_ms) begin
        in_elapsed = '0;
        for (int p = aipq_pkg::PinSail; p <= aipq_pkg::PinTco; p++) begin
          qual_flags[p] = qual_flags[aipq_pkg::PinVdet] &&
                          (edge_cnt[p] > shadow_cfg.input_edge_threshold);
          edge_cnt[p] = '0;
        end
      end
    end
    flags_due.push_back(qual_flags);
  endtask

  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_flags();
    flags_t want;
    if (flags_due.size() == 0) begin
      $error("flags transfer with no expected result pending");
      fail_count++;
    end else begin
      want = flags_due.pop_front();
      check_field("ac_present", want[aipq_pkg::PinVdet], flags_ch.ac_present);
      check_field("sail_switch_on", want[aipq_pkg::PinSail], flags_ch.sail_switch_on);
      check_field("power_button_on", want[aipq_pkg::PinPower], flags_ch.power_button_on);
      check_field("tco_on", want[aipq_pkg::PinTco], flags_ch.tco_on);
    end
  endtask

  // Values are read at the clock edge before any flop of this edge updates.
  // Results are checked before the new sample is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (flags_ch.valid && flags_ch.ready) check_flags();
      if (sample_ch.valid && sample_ch.ready) begin
        qualify_sample(sample_ch.pin_levels, sample_ch.ms_tick);
      end
      if ((flags_ch.valid && flags_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    flags_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_sample(input logic [NumPins-1:0] levels, input logic tick);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.pin_levels <= levels;
    sample_ch.ms_tick    <= tick;
    last_sent = levels;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (flags_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input aipq_pkg::cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      aipq_pkg::CfgAcWindow:    shadow_cfg.ac_window_ms = value;
      aipq_pkg::CfgInWindow:    shadow_cfg.input_window_ms = value;
      aipq_pkg::CfgAcThreshold: shadow_cfg.ac_edge_threshold = value;
      aipq_pkg::CfgInThreshold: shadow_cfg.input_edge_threshold = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CfgW-1:0] ac_win, input logic [CfgW-1:0] in_win,
                                input logic [CfgW-1:0] ac_thr, input logic [CfgW-1:0] in_thr);
    write_reg(aipq_pkg::CfgAcWindow, ac_win);
    write_reg(aipq_pkg::CfgInWindow, in_win);
    write_reg(aipq_pkg::CfgAcThreshold, ac_thr);
    write_reg(aipq_pkg::CfgInThreshold, in_thr);
    cfg_we <= 1'b0;
  endtask

  // Pins toggle at a rate picked per pin every 16 samples, so edge counts land
  // both below and above the thresholds; one sample in ten is plain noise.
  task automatic send_random(input int count, input int tick_pct);
    int                 toggle_pct [NumPins];
    logic [NumPins-1:0] levels;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) begin
        foreach (toggle_pct[p]) begin
          case ($urandom_range(3))
            0:       toggle_pct[p] = 0;
            1:       toggle_pct[p] = 5;
            2:       toggle_pct[p] = 30;
            default: toggle_pct[p] = 90;
          endcase
        end
      end
      if ($urandom_range(9) == 0) begin
        levels = NumPins'($urandom);
      end else begin
        levels = last_sent;
        for (int p = 0; p < NumPins; p++) begin
          if ($urandom_range(99) < toggle_pct[p]) levels[p] = ~levels[p];
        end
      end
      send_sample(levels, $urandom_range(99) < tick_pct);
    end
  endtask

  task automatic send_toggles(input int count, input logic tick);
    for (int n = 0; n < count; n++) send_sample(~last_sent, tick);
  endtask

  task automatic test_reset_defaults();
    send_random(200, 80);
    wait_drained();
  endtask

  task automatic test_directed_cases();
    apply_settings(8'd1, 8'd2, 8'd0, 8'd0);
    // Flush both windows with no edges pending.
    send_sample(4'h0, 1'b0);
    send_sample(4'h0, 1'b1);
    send_sample(4'h0, 1'b1);
    // A voltage-detect edge without a tick, then the window that qualifies it.
    send_sample(4'h1, 1'b0);
    send_sample(4'h1, 1'b1);
    // Both windows end together; the inputs see the fresh AC flag.
    send_sample(4'hE, 1'b1);
    // No edges: AC drops, then the switch inputs go off despite their edges.
    send_sample(4'hE, 1'b1);
    send_sample(4'hC, 1'b1);
    send_sample(4'hF, 1'b0);
    send_sample(4'h0, 1'b0);
    send_sample(4'h0, 1'b1);
    send_sample(4'hF, 1'b1);
    send_sample(4'hF, 1'b0);
    send_sample(4'h5, 1'b1);
    send_sample(4'hA, 1'b1);
    wait_drained();
  endtask

  task automatic test_shortest_windows();
    apply_settings(8'd1, 8'd1, 8'd0, 8'd1);
    send_random(60, 50);
    wait_drained();
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      apply_settings(CfgW'($urandom_range(1, 8)), CfgW'($urandom_range(1, 16)),
                     CfgW'($urandom_range(0, 10)), CfgW'($urandom_range(0, 10)));
      send_random(50, 50);
      wait_drained();
    end
  endtask

  // Counters saturate at their maximum, which never exceeds a threshold of 255
  // but does exceed 254. The windows are also shortened to or below the running timers.
  task automatic test_counter_saturation();
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255);
    send_toggles(60, 1'b1);
    send_toggles(200, 1'b0);
    wait_drained();
    apply_settings(8'd50, 8'd60, 8'd255, 8'd255);
    send_sample(last_sent, 1'b1);
    send_toggles(260, 1'b0);
    wait_drained();
    apply_settings(8'd1, 8'd1, 8'd254, 8'd254);
    send_sample(last_sent, 1'b1);
    send_sample(last_sent, 1'b1);
    wait_drained();
  endtask

  task automatic test_mixed_random();
    apply_settings(CfgW'($urandom_range(1, 6)), CfgW'($urandom_range(1, 12)),
                   CfgW'($urandom_range(0, 6)), CfgW'($urandom_range(0, 6)));
    send_random(60, 40);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_ch.valid      <= 1'b0;
    sample_ch.pin_levels <= '0;
    sample_ch.ms_tick    <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= aipq_pkg::CfgAcWindow;
    cfg_wdata            <= '0;
    fail_count  = 0;
    idle_cycles = 0;
    last_sent   = '0;
    clear_shadow();
    set_idling(37, 70);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_cases();
    test_shortest_windows();
    set_idling(70, 37);
    test_random_settings();
    set_idling(0, 0);
    test_counter_saturation();
    test_mixed_random();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
